// File: design/ncbs_pkg.sv
package ncbs_pkg;

  // deepest brace nesting that the depth counter keeps
  localparam int unsigned MAX_DEPTH = 255;
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_NL     = 8'h0a;

  typedef enum logic [3:0] {
    LX_CODE,
    LX_DQ,
    LX_DQ_ESC,
    LX_SQ,
    LX_SQ_ESC,
    LX_SLASH,
    LX_LINE,
    LX_BLOCK,
    LX_BLOCK_STAR
  } lex_state_t;

  typedef struct packed {
    lex_state_t         lex;
    logic [DEPTH_W-1:0] depth;
    logic [7:0]         last_char;
    logic               recovery_mode;
    logic               finished;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
    logic       begin_req;
    logic       recovery;
  } item_t;

  typedef struct packed {
    logic       taken;
    logic       token_end;
    logic       symbol;
    logic [7:0] nesting;
  } result_t;

  localparam scan_state_t SCAN_RESET = '{
    lex:           LX_CODE,
    depth:         '0,
    last_char:     '0,
    recovery_mode: 1'b0,
    finished:      1'b0
  };

endpackage

// File: design/ncbs_in_if.sv
interface ncbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;
  logic       begin_req;
  logic       recovery;

  modport source (output valid, ch, at_end, begin_req, recovery, input ready);
  modport sink (input valid, ch, at_end, begin_req, recovery, output ready);
endinterface

// File: design/ncbs_out_if.sv
interface ncbs_out_if;
  logic       valid;
  logic       ready;
  logic       taken;
  logic       token_end;
  logic       symbol;
  logic [7:0] nesting;

  modport source (output valid, taken, token_end, symbol, nesting, input ready);
  modport sink (input valid, taken, token_end, symbol, nesting, output ready);
endinterface

// File: design/ncbs_step.sv
module ncbs_step import ncbs_pkg::*; (
  input  scan_state_t cur,
  input  item_t       it,
  output scan_state_t nxt,
  output result_t     res
);

  scan_state_t st;
  logic        ends;
  logic        take;
  logic        do_code;
  logic [7:0]  c;

  always_comb begin
    st      = cur;
    ends    = 1'b0;
    take    = 1'b0;
    do_code = 1'b0;
    c       = it.ch;

    if (it.begin_req) begin
      st               = SCAN_RESET;
      st.recovery_mode = it.recovery;
    end

    if (!st.finished) begin
      if (it.at_end) begin
        ends = 1'b1;
      end else begin
        unique case (st.lex)
          LX_DQ: begin
            if (c == CH_DQUOTE) st.lex = LX_CODE;
            else if (c == CH_BSLASH) st.lex = LX_DQ_ESC;
          end
          LX_DQ_ESC: st.lex = LX_DQ;
          LX_SQ: begin
            if (c == CH_SQUOTE) st.lex = LX_CODE;
            else if (c == CH_BSLASH) st.lex = LX_SQ_ESC;
          end
          LX_SQ_ESC: st.lex = LX_SQ;
          LX_SLASH: begin
            // a lone slash hands this character back to code context
            if (c == CH_STAR) st.lex = LX_BLOCK;
            else if (c == CH_SLASH) st.lex = LX_LINE;
            else do_code = 1'b1;
          end
          LX_LINE: begin
            if (c == CH_NL) st.lex = LX_CODE;
          end
          LX_BLOCK: begin
            if (c == CH_STAR) st.lex = LX_BLOCK_STAR;
          end
          LX_BLOCK_STAR: begin
            if (c == CH_SLASH) st.lex = LX_CODE;
            else if (c != CH_STAR) st.lex = LX_BLOCK;
          end
          default: do_code = 1'b1;
        endcase

        if (do_code) begin
          st.lex = LX_CODE;
          if (st.recovery_mode) begin
            if (c == CH_PERCENT || c == CH_SEMI) begin
              ends = 1'b1;
            end else begin
              if (c == CH_DQUOTE) st.lex = LX_DQ;
              else if (c == CH_SQUOTE) st.lex = LX_SQ;
              st.last_char = c;
            end
          end else if (c == CH_RBRACE && st.depth == '0) begin
            ends = 1'b1;
          end else begin
            case (c)
              CH_DQUOTE: st.lex = LX_DQ;
              CH_SQUOTE: st.lex = LX_SQ;
              CH_SLASH:  st.lex = LX_SLASH;
              CH_LBRACE: begin
                if (st.depth < DEPTH_W'(MAX_DEPTH)) st.depth = st.depth + DEPTH_W'(1);
              end
              CH_RBRACE: begin
                if (st.depth != '0) st.depth = st.depth - DEPTH_W'(1);
              end
              CH_PERCENT: begin
                // "<%" opens like a brace
                if (st.last_char == CH_LT && st.depth < DEPTH_W'(MAX_DEPTH))
                  st.depth = st.depth + DEPTH_W'(1);
              end
              CH_GT: begin
                // "%>" closes, floored at zero
                if (st.last_char == CH_PERCENT && st.depth != '0)
                  st.depth = st.depth - DEPTH_W'(1);
              end
              default: ;
            endcase
            st.last_char = c;
          end
        end
        take = !ends;
      end
      if (ends) st.finished = 1'b1;
    end

    nxt           = st;
    res.taken     = take;
    res.token_end = ends;
    res.symbol    = st.recovery_mode;
    res.nesting   = 8'(st.depth);
  end

endmodule

// File: design/nested_code_block_scanner.sv
// a request is held in the input register and moves into the result register once that register is free
// throughput: one character per cycle while the result is not stalled; the scan state is updated in the cycle
// the registered request moves into the result register
// reset: synchronous, clears the scan state and the input and result register valid bits
module nested_code_block_scanner import ncbs_pkg::*; (
  input logic        clk,
  input logic        rst,
  ncbs_in_if.sink    item,
  ncbs_out_if.source result
);

  logic        in_vld;
  item_t       in_q;
  scan_state_t st;
  scan_state_t st_next;
  logic        out_vld;
  result_t     res_q;
  result_t     res_next;
  logic        out_free;
  logic        advance;

  assign out_free   = !out_vld || result.ready;
  assign advance    = in_vld && out_free;
  assign item.ready = !in_vld || advance;

  ncbs_step u_step (
    .cur (st),
    .it  (in_q),
    .nxt (st_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
      st      <= SCAN_RESET;
    end else begin
      if (item.ready) in_vld <= item.valid;
      if (advance) st <= st_next;
      if (out_free) out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_q.ch        <= item.ch;
      in_q.at_end    <= item.at_end;
      in_q.begin_req <= item.begin_req;
      in_q.recovery  <= item.recovery;
    end
    if (advance) res_q <= res_next;
  end

  assign result.valid     = out_vld;
  assign result.taken     = res_q.taken;
  assign result.token_end = res_q.token_end;
  assign result.symbol    = res_q.symbol;
  assign result.nesting   = res_q.nesting;

  a_excl: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.taken && result.token_end))
    else $error("taken and token_end both set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!advance && !rst) |=> $stable(st))
    else $error("scan state moved without a request");

  a_done: assert property (@(posedge clk) disable iff (rst)
    (advance && res_next.token_end) |=> st.finished)
    else $error("token end did not mark the scan finished");

  a_after: assert property (@(posedge clk) disable iff (rst)
    (advance && st.finished && !in_q.begin_req) |=>
      (out_vld && !res_q.taken && !res_q.token_end))
    else $error("character taken after the token ended");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    st.depth <= DEPTH_W'(MAX_DEPTH))
    else $error("depth above limit");

endmodule
